@@ sv/kwq_pkg.sv @@
// Package for the keyed waitlist queue: sizes, codes and the control program.
`timescale 1ns / 1ps
package kwq_pkg;

   // Sizing
   localparam int QUEUE_DEPTH = 8;
   localparam int KEY_BITS    = 32;
   localparam int REQ_KEY_W   = 32;
   localparam int KEY_W       = (KEY_BITS < REQ_KEY_W) ? KEY_BITS : REQ_KEY_W;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Operation codes
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;

   // Result status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_LISTED = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   // Datapath action selected by a control word
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LATCH,
      ACT_SCAN,
      ACT_SHIFT,
      ACT_REMOVE,
      ACT_RESOLVE,
      ACT_REPLY
   } act_type;

   // Branch condition tested by a control word
   typedef enum logic [2:0] {
      C_ALWAYS,
      C_REQ,
      C_SCAN_END,
      C_CANCEL_HIT,
      C_SHIFT_END,
      C_RSP
   } cond_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_FETCH    = 3'd0;
   localparam step_type STEP_SCAN     = 3'd1;
   localparam step_type STEP_DISPATCH = 3'd2;
   localparam step_type STEP_SHIFT    = 3'd3;
   localparam step_type STEP_REMOVE   = 3'd4;
   localparam step_type STEP_RESOLVE  = 3'd5;
   localparam step_type STEP_REPLY    = 3'd6;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } uword_type;

   // Control store: one word per step
   function automatic uword_type ucode(input step_type step);
      uword_type w;
      unique case (step)
         STEP_FETCH:    w = '{ACT_LATCH,   C_REQ,        STEP_SCAN,     STEP_FETCH};
         STEP_SCAN:     w = '{ACT_SCAN,    C_SCAN_END,   STEP_DISPATCH, STEP_SCAN};
         STEP_DISPATCH: w = '{ACT_NONE,    C_CANCEL_HIT, STEP_SHIFT,    STEP_RESOLVE};
         STEP_SHIFT:    w = '{ACT_SHIFT,   C_SHIFT_END,  STEP_REMOVE,   STEP_SHIFT};
         STEP_REMOVE:   w = '{ACT_REMOVE,  C_ALWAYS,     STEP_REPLY,    STEP_REPLY};
         STEP_RESOLVE:  w = '{ACT_RESOLVE, C_ALWAYS,     STEP_REPLY,    STEP_REPLY};
         STEP_REPLY:    w = '{ACT_REPLY,   C_RSP,        STEP_FETCH,    STEP_REPLY};
         default:       w = '{ACT_NONE,    C_ALWAYS,     STEP_FETCH,    STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

@@ sv/kwq_if.sv @@
// Valid/ready channel interfaces for the request and response items.
`timescale 1ns / 1ps
interface kwq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] reader_key;

   modport source (output valid, output mode, output reader_key, input ready);
   modport sink   (input valid, input mode, input reader_key, output ready);
endinterface

interface kwq_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [3:0] position;
   logic [3:0] occupancy;

   modport source (output valid, output status, output position, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input position, input occupancy,
                   output ready);
endinterface

@@ sv/keyed_waitlist_queue.sv @@
// Keyed waitlist queue: microcoded sequencer over a bounded list of keys.
`timescale 1ns / 1ps
// A first-come list of up to QUEUE_DEPTH keys. Each request item adds, cancels or
// ranks one key, and one response item gives status, 1-based position and the
// occupancy after the operation. Items are handled one at a time by a small
// microprogram stepping through fetch, scan, dispatch, shift and remove or resolve,
// and reply. The scan looks at one stored key per cycle and a cancel moves one key
// per cycle after the hit. The next request is taken the cycle after the response
// is. The key store is read at a single address per cycle, which sets the pace of
// the scan and the shift.
module keyed_waitlist_queue
   import kwq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   kwq_req_if.sink   req_if,
   kwq_rsp_if.source rsp_if
);

   // Key store
   logic [KEY_W-1:0]  keys_ff [QUEUE_DEPTH];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [KEY_W-1:0]  wr_data;

   // Sequencer and datapath registers
   step_type         step_ff,     step_in;
   logic [CNT_W-1:0] idx_ff,      idx_in;
   logic [CNT_W-1:0] count_ff,    count_in;
   logic             found_ff,    found_in;
   logic [1:0]       mode_ff,     mode_in;
   logic [KEY_W-1:0] key_ff,      key_in;
   logic [1:0]       status_ff,   status_in;
   logic [CNT_W-1:0] position_ff, position_in;

   uword_type        uw;
   logic [CNT_W-1:0] idx_inc;
   logic [CNT_W-1:0] rd_addr;
   logic [KEY_W-1:0] rd_key;
   logic             in_range;
   logic             hit;
   logic             shift_more;
   logic             full;
   logic             cond_ok;
   logic [CNT_W+3:0] pos_ext;
   logic [CNT_W+3:0] occ_ext;

   // Decode current control word and datapath flags
   always_comb begin
      uw         = ucode(step_ff);
      idx_inc    = CNT_W'(idx_ff + 1'b1);
      rd_addr    = (uw.act == ACT_SHIFT) ? idx_inc : idx_ff;
      rd_key     = keys_ff[rd_addr[ADDR_W-1:0]];
      in_range   = idx_ff < count_ff;
      hit        = in_range && (rd_key == key_ff);
      shift_more = {1'b0, idx_ff} + 1'b1 < {1'b0, count_ff};
      full       = count_ff == CNT_W'(QUEUE_DEPTH);
   end

   // Branch condition and next step
   always_comb begin
      unique case (uw.cond)
         C_ALWAYS:     cond_ok = 1'b1;
         C_REQ:        cond_ok = req_if.valid;
         C_SCAN_END:   cond_ok = !in_range || hit;
         C_CANCEL_HIT: cond_ok = (mode_ff == MODE_CANCEL) && found_ff;
         C_SHIFT_END:  cond_ok = !shift_more;
         C_RSP:        cond_ok = rsp_if.ready;
         default:      cond_ok = 1'b1;
      endcase
      step_in = cond_ok ? uw.on_true : uw.on_false;
   end

   // Datapath actions
   always_comb begin
      idx_in      = idx_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      status_in   = status_ff;
      position_in = position_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[ADDR_W-1:0];
      wr_data     = rd_key;
      unique case (uw.act)
         ACT_LATCH: begin
            if (req_if.valid) begin
               mode_in  = req_if.mode;
               key_in   = req_if.reader_key[KEY_W-1:0];
               idx_in   = '0;
               found_in = 1'b0;
            end
         end
         ACT_SCAN: begin
            if (hit) begin
               found_in = 1'b1;
            end else if (in_range) begin
               idx_in = idx_inc;
            end
         end
         ACT_SHIFT: begin
            // move the next key one place forward
            if (shift_more) begin
               wr_en  = 1'b1;
               idx_in = idx_inc;
            end
         end
         ACT_REMOVE: begin
            count_in    = CNT_W'(count_ff - 1'b1);
            status_in   = ST_DONE;
            position_in = '0;
         end
         ACT_RESOLVE: begin
            if (mode_ff == MODE_ADD) begin
               if (found_ff) begin
                  status_in   = ST_LISTED;
                  position_in = idx_inc;
               end else if (full) begin
                  status_in   = ST_FULL;
                  position_in = '0;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = count_ff[ADDR_W-1:0];
                  wr_data     = key_ff;
                  count_in    = CNT_W'(count_ff + 1'b1);
                  status_in   = ST_DONE;
                  position_in = CNT_W'(count_ff + 1'b1);
               end
            end else if (mode_ff == MODE_CANCEL) begin
               // a cancel that hits goes through the shift steps instead
               status_in   = ST_ABSENT;
               position_in = '0;
            end else if (found_ff) begin
               status_in   = ST_DONE;
               position_in = idx_inc;
            end else begin
               status_in   = ST_ABSENT;
               position_in = '0;
            end
         end
         ACT_NONE, ACT_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   // Key store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys_ff[wr_addr] <= wr_data;
      end
   end

   // Sequencer state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_FETCH;
         count_ff <= '0;
      end else begin
         step_ff  <= step_in;
         count_ff <= count_in;
      end
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      position_ff <= position_in;
   end

   // Handshakes and response payload
   always_comb begin
      pos_ext            = {4'b0000, position_ff};
      occ_ext            = {4'b0000, count_ff};
      req_if.ready       = uw.act == ACT_LATCH;
      rsp_if.valid       = uw.act == ACT_REPLY;
      rsp_if.status      = status_ff;
      rsp_if.position    = pos_ext[3:0];
      rsp_if.occupancy   = occ_ext[3:0];
   end

endmodule

@@ sv/kwq_checker.sv @@
// Port-level checks for the keyed waitlist queue, bound to the top level.
`timescale 1ns / 1ps
module kwq_checker
   import kwq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_position,
   input logic [3:0] rsp_occupancy
);

   // One item at a time: no request taken right after one was accepted
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted twice in a row");

   // A response goes away once it is taken
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("response repeated");

   // Misses and full list report no position
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_ABSENT)
      |-> rsp_position == 4'd0)
      else $error("position set on a miss");

   // A listed key always has a position
   a_listed_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LISTED |-> rsp_position != 4'd0)
      else $error("listed key without position");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_position) && $stable(rsp_occupancy))
      else $error("stalled response changed");

endmodule

bind keyed_waitlist_queue kwq_checker u_kwq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_position  (rsp_if.position),
   .rsp_occupancy (rsp_if.occupancy)
);

@@ sim/tb_keyed_waitlist_queue.sv @@
// Self-checking testbench for the keyed waitlist queue with randomized valid/ready pacing.
`timescale 1ns / 1ps
module tb_keyed_waitlist_queue;
   import kwq_pkg::*;

   // Rank codes not named in the package
   localparam logic [1:0] MODE_RANK  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam int RANDOM_ITEMS = 650;
   localparam int POOL_SIZE    = 12;
   localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 24;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] key;
   } request_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] position;
      logic [3:0] occupancy;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kwq_req_if req_if ();
   kwq_rsp_if rsp_if ();

   keyed_waitlist_queue DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #2 clock = ~clock;

   // Shadow copy of the waiting list
   logic [KEY_W-1:0] list_keys [QUEUE_DEPTH];
   int               list_count = 0;

   request_type req_items [$];
   reply_type   awaited_replies [$];
   logic [31:0] key_pool [POOL_SIZE];
   int          items_total    = 0;
   int          items_accepted = 0;
   int          replies_seen   = 0;
   int          errors         = 0;
   int          status_tally [4];
   int          req_gap, req_calm, rsp_stall, rsp_calm;
   int          cycles = 0;

   // Applies one operation to the shadow list and returns the reply it should produce
   function automatic reply_type waitlist_apply(input logic [1:0] mode, input logic [31:0] key);
      reply_type        r;
      int               hit;
      logic [KEY_W-1:0] k;
      k = key[KEY_W-1:0];
      hit = -1;
      r.position = 4'd0;
      for (int i = 0; i < list_count; i++)
         if (hit < 0 && list_keys[i] == k) hit = i;
      case (mode)
         MODE_ADD: begin
            if (hit >= 0) begin
               r.status   = ST_LISTED;
               r.position = 4'(hit + 1);
            end else if (list_count >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_keys[list_count] = k;
               list_count++;
               r.status   = ST_DONE;
               r.position = 4'(list_count);
            end
         end
         MODE_CANCEL: begin
            if (hit >= 0) begin
               for (int i = hit; i + 1 < list_count; i++) list_keys[i] = list_keys[i + 1];
               list_count--;
               r.status = ST_DONE;
            end else begin
               r.status = ST_ABSENT;
            end
         end
         // rank query; the spare code behaves the same
         default: begin
            if (hit >= 0) begin
               r.status   = ST_DONE;
               r.position = 4'(hit + 1);
            end else begin
               r.status = ST_ABSENT;
            end
         end
      endcase
      r.occupancy = 4'(list_count);
      return r;
   endfunction

   task automatic queue_request(input logic [1:0] mode, input logic [31:0] key);
      request_type it;
      it.mode = mode;
      it.key  = key;
      req_items.push_back(it);
      items_total++;
   endtask

   // Mostly pool keys so adds, cancels and ranks hit; some one-bit near misses and fresh keys
   function automatic logic [31:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 88)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'd1 << $urandom_range(0, 31));
      return $urandom;
   endfunction

   // Request driver: one item in flight, random gap before each next item
   always @(posedge clock) begin : drive_req
      request_type nxt;
      reply_type   pred;
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.mode       <= MODE_ADD;
         req_if.reader_key <= 32'd0;
         req_gap           <= 0;
         req_calm          <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            pred = waitlist_apply(req_if.mode, req_if.reader_key);
            awaited_replies.push_back(pred);
            items_accepted++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (req_gap != 0) begin
               req_if.valid <= 1'b0;
               req_gap      <= req_gap - 1;
            end else if (req_items.size() != 0) begin
               nxt = req_items.pop_front();
               req_if.valid      <= 1'b1;
               req_if.mode       <= nxt.mode;
               req_if.reader_key <= nxt.key;
               if (req_calm != 0) begin
                  req_gap  <= 0;
                  req_calm <= req_calm - 1;
               end else begin
                  req_gap <= $urandom_range(0, 9);
                  if ($urandom_range(0, 15) == 0) req_calm <= $urandom_range(10, 40);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each item against the oldest prediction, then stalls at random
   always @(posedge clock) begin : watch_rsp
      reply_type exp_r;
      int        n;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
         rsp_calm     <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected response status=%0d position=%0d occupancy=%0d",
                     $time, rsp_if.status, rsp_if.position, rsp_if.occupancy);
         end else begin
            exp_r = awaited_replies.pop_front();
            status_tally[exp_r.status]++;
            if (rsp_if.status !== exp_r.status) begin
               errors++;
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, exp_r.status, rsp_if.status);
            end
            if (rsp_if.position !== exp_r.position) begin
               errors++;
               $display("%0t: position mismatch: expected %0d, got %0d",
                        $time, exp_r.position, rsp_if.position);
            end
            if (rsp_if.occupancy !== exp_r.occupancy) begin
               errors++;
               $display("%0t: occupancy mismatch: expected %0d, got %0d",
                        $time, exp_r.occupancy, rsp_if.occupancy);
            end
         end
         if (rsp_calm != 0) begin
            n = 0;
            rsp_calm <= rsp_calm - 1;
         end else begin
            n = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0) rsp_calm <= $urandom_range(10, 40);
         end
         rsp_if.ready <= (n == 0);
         rsp_stall    <= (n == 0) ? 0 : n - 1;
      end else if (rsp_stall != 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= rsp_stall - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d of %0d items accepted, %0d responses pending",
                  $time, items_accepted, items_total, awaited_replies.size());
         $display("keyed_waitlist_queue regression: fail");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      int add_pct, roll;
      logic [1:0] m;
      for (int s = 0; s < 4; s++) status_tally[s] = 0;
      for (int p = 0; p < POOL_SIZE; p++) key_pool[p] = $urandom;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;

      // Directed: empty list, extremes, duplicates, full list, cancels at head, middle, tail
      queue_request(MODE_RANK,   32'h0000_0000);
      queue_request(MODE_CANCEL, 32'hFFFF_FFFF);
      queue_request(MODE_ADD,    32'h0000_0000);
      queue_request(MODE_ADD,    32'hFFFF_FFFF);
      queue_request(MODE_ADD,    32'h0000_0000);
      queue_request(MODE_RANK,   32'hFFFF_FFFF);
      queue_request(MODE_SPARE,  32'hFFFF_FFFF);
      queue_request(MODE_SPARE,  32'h1234_5678);
      queue_request(MODE_ADD,    32'h5555_5555);
      queue_request(MODE_ADD,    32'hAAAA_AAAA);
      queue_request(MODE_ADD,    32'h8000_0000);
      queue_request(MODE_ADD,    32'h0000_0001);
      queue_request(MODE_ADD,    32'h7FFF_FFFF);
      queue_request(MODE_ADD,    32'hFFFF_FFFE);
      queue_request(MODE_ADD,    32'h1234_5678);
      queue_request(MODE_ADD,    32'h5555_5555);
      queue_request(MODE_CANCEL, 32'h8000_0000);
      queue_request(MODE_RANK,   32'h0000_0001);
      queue_request(MODE_CANCEL, 32'h0000_0000);
      queue_request(MODE_CANCEL, 32'hFFFF_FFFE);
      queue_request(MODE_CANCEL, 32'h0BAD_F00D);
      queue_request(MODE_ADD,    32'h1234_5678);
      queue_request(MODE_RANK,   32'h1234_5678);

      // Random: phases of 50 items that lean toward filling or draining the list
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) add_pct = $urandom_range(25, 65);
         roll = $urandom_range(0, 99);
         if (roll < add_pct)            m = MODE_ADD;
         else if (roll < add_pct + 30)  m = MODE_CANCEL;
         else if (roll < 95)            m = MODE_RANK;
         else                           m = MODE_SPARE;
         queue_request(m, pick_key());
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (items_accepted == items_total);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (adds, cancels, rank and spare-code queries), %0d responses.",
               items_accepted, replies_seen);
      $display("Outcomes: %0d done/found, %0d already listed, %0d full, %0d not listed.",
               status_tally[ST_DONE], status_tally[ST_LISTED], status_tally[ST_FULL],
               status_tally[ST_ABSENT]);
      if (errors == 0) begin
         $display("keyed_waitlist_queue regression: pass");
      end else begin
         $display("keyed_waitlist_queue regression: fail");
      end
      $finish;
   end

endmodule
